// ----- rtl/core/c2g_pkg.sv -----
// c2g_pkg: shared types, constants and the arctangent step table for the
// cartesian to geodetic converter. No dependencies.
package c2g_pkg;

  localparam int COORD_WIDTH_DEF = 48;
  localparam int ANGLE_WIDTH_DEF = 32;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECC    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXIT  = 4'd3;

  localparam logic [39:0] RADIUS_RST = 40'd6531211571;
  localparam logic [31:0] ECC_RST    = 32'd28752142;
  localparam logic [15:0] THRESH_RST = 16'd1;
  localparam logic [6:0]  MAXIT_RST  = 7'd16;
  localparam logic [6:0]  MAXIT_CAP  = 7'd64;

  localparam logic [63:0] INT64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LOW32      = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] INV_PI_Q64 = 64'h517C_C1B7_2722_0A94;

  localparam int CORDIC_STEPS = 62;
  localparam int CORDIC_IDX_W = 6;

  typedef enum logic [4:0] {
    OP_LOAD  = 5'd0,
    OP_RHOX  = 5'd1,
    OP_RHOY  = 5'd2,
    OP_DZ0   = 5'd3,
    OP_ZDZ   = 5'd4,
    OP_NH2   = 5'd5,
    OP_NH    = 5'd6,
    OP_SIN   = 5'd7,
    OP_S2    = 5'd8,
    OP_ES2   = 5'd9,
    OP_ROOT  = 5'd10,
    OP_N     = 5'd11,
    OP_NE    = 5'd12,
    OP_DMAG  = 5'd13,
    OP_CHECK = 5'd14,
    OP_RHO   = 5'd15,
    OP_LON   = 5'd16,
    OP_LAT   = 5'd17,
    OP_OUT   = 5'd18
  } op_e;

  typedef enum logic {
    RD_SQRT = 1'b0,
    RD_DIV  = 1'b1
  } rd_mode_e;

  typedef struct packed {
    logic go;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic zero;
    logic conv;
    logic stuck;
  } status_t;

  function automatic logic [63:0] small_div(input logic [63:0] num, input logic [63:0] dv);
    logic [63:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= dv) begin
        rem  = rem - dv;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] atan_calc(input int unsigned i);
    logic [63:0]  sum;
    logic [63:0]  term;
    logic [127:0] prod;
    int unsigned  p;
    sum = '0;
    if (i == 0) begin
      return 64'd1 << 61;
    end
    for (int unsigned n = 0; n < 33; n++) begin
      p = i * (2 * n + 1);
      if (p <= 64) begin
        term = small_div(64'd1 << (64 - p), 64'(2 * n + 1));
        if (n[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    prod = {64'd0, sum} * {64'd0, INV_PI_Q64};
    return {1'b0, prod[127:65]};
  endfunction

  function automatic logic [CORDIC_STEPS-1:0][63:0] build_atan_tab();
    logic [CORDIC_STEPS-1:0][63:0] t;
    for (int unsigned i = 0; i < CORDIC_STEPS; i++) begin
      t[i] = atan_calc(i);
    end
    return t;
  endfunction

  localparam logic [CORDIC_STEPS-1:0][63:0] ATAN_TAB = build_atan_tab();

endpackage

// ----- rtl/core/c2g_mul.sv -----
// c2g_mul: 64 x 64 unsigned multiplier, one 32 x 32 partial product a cycle.
// Depends on c2g_pkg.
module c2g_mul import c2g_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] prod_o
);

  logic [63:0]  a_q, b_q, pp_q;
  logic [127:0] acc_q, pp_sh;
  logic [1:0]   cnt_q, sh_q;
  logic         run_q, ppv_q, done_q;
  logic [31:0]  op_a, op_b;

  always_comb begin
    op_a = cnt_q[1] ? a_q[63:32] : a_q[31:0];
    op_b = cnt_q[0] ? b_q[63:32] : b_q[31:0];
    case (sh_q)
      2'd0:    pp_sh = {64'd0, pp_q};
      2'd1:    pp_sh = {32'd0, pp_q, 32'd0};
      2'd2:    pp_sh = {32'd0, pp_q, 32'd0};
      default: pp_sh = {pp_q, 64'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      ppv_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      ppv_q  <= run_q;
      done_q <= ppv_q && (sh_q == 2'd3);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (ppv_q) begin
      acc_q <= acc_q + pp_sh;
    end
    if (run_q) begin
      pp_q <= {32'd0, op_a} * {32'd0, op_b};
      sh_q <= cnt_q;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ----- rtl/core/c2g_rootdiv.sv -----
// c2g_rootdiv: shared bit-serial unit, floor square root of 128 bits or
// 128 / 64 division with saturation, one result bit a cycle. Depends on c2g_pkg.
module c2g_rootdiv import c2g_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  rd_mode_e     mode_i,
  input  logic [127:0] num_i,
  input  logic [63:0]  den_i,
  output logic         done_o,
  output logic [63:0]  res_o
);

  rd_mode_e     mode_q;
  logic [127:0] num_q;
  logic [63:0]  den_q, res_q;
  logic [67:0]  rem_q, rem_sh, trial;
  logic [64:0]  full;
  logic [5:0]   cnt_q;
  logic         run_q, sat_q, done_q;

  always_comb begin
    rem_sh = {rem_q[65:0], num_q[127:126]};
    trial  = {2'b00, res_q, 2'b01};
    full   = {rem_q[63:0], num_q[127]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == 6'd63);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mode_q <= mode_i;
      den_q  <= den_i;
      res_q  <= '0;
      sat_q  <= (den_i == 64'd0) || (num_i[127:64] >= den_i);
      if (mode_i == RD_DIV) begin
        rem_q <= {4'd0, num_i[127:64]};
        num_q <= {num_i[63:0], 64'd0};
      end else begin
        rem_q <= '0;
        num_q <= num_i;
      end
    end else if (run_q) begin
      if (mode_q == RD_DIV) begin
        num_q <= {num_q[126:0], 1'b0};
        if (full >= {1'b0, den_q}) begin
          rem_q <= {4'd0, 64'(full - {1'b0, den_q})};
          res_q <= {res_q[62:0], 1'b1};
        end else begin
          rem_q <= {4'd0, full[63:0]};
          res_q <= {res_q[62:0], 1'b0};
        end
      end else begin
        num_q <= {num_q[125:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q <= rem_sh - trial;
          res_q <= {res_q[62:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          res_q <= {res_q[62:0], 1'b0};
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = (mode_q == RD_DIV && sat_q) ? '1 : res_q;

endmodule

// ----- rtl/core/c2g_cordic.sv -----
// c2g_cordic: vectoring cordic atan2 with one-bit-a-cycle normalization,
// angle in 2^64 units per turn. Depends on c2g_pkg.
module c2g_cordic import c2g_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        yneg_i,
  input  logic [63:0] ay_i,
  input  logic        xneg_i,
  input  logic [63:0] ax_i,
  output logic        done_o,
  output logic [63:0] angle_o
);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_NORM = 3'b010,
    C_ITER = 3'b100
  } cor_st_e;

  cor_st_e                  st_q;
  logic [63:0]              mx_q, my_q, ang_q, res_q, ang_nx, step;
  logic signed [63:0]       x_q, y_q, xs, ys, x_nx, y_nx;
  logic [CORDIC_IDX_W-1:0]  idx_q;
  logic                     yn_q, base_q, done_q;
  logic                     is_zero, is_big, is_small;

  always_comb begin
    is_zero  = (mx_q == 64'd0) && (my_q == 64'd0);
    is_big   = (mx_q[63:61] != 3'd0) || (my_q[63:61] != 3'd0);
    is_small = (mx_q[63:60] == 4'd0) && (my_q[63:60] == 4'd0);
    xs       = x_q >>> idx_q;
    ys       = y_q >>> idx_q;
    step     = ATAN_TAB[idx_q];
    if (!y_q[63]) begin
      x_nx   = x_q + ys;
      y_nx   = y_q - xs;
      ang_nx = ang_q + step;
    end else begin
      x_nx   = x_q - ys;
      y_nx   = y_q + xs;
      ang_nx = ang_q - step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= C_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        C_IDLE: begin
          if (start_i) begin
            st_q <= C_NORM;
          end
        end
        C_NORM: begin
          if (is_zero) begin
            done_q <= 1'b1;
            st_q   <= C_IDLE;
          end else if (!is_big && !is_small) begin
            st_q <= C_ITER;
          end
        end
        C_ITER: begin
          if (idx_q == CORDIC_IDX_W'(CORDIC_STEPS - 1)) begin
            done_q <= 1'b1;
            st_q   <= C_IDLE;
          end
        end
        default: st_q <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      C_IDLE: begin
        if (start_i) begin
          mx_q   <= ax_i;
          my_q   <= ay_i;
          yn_q   <= yneg_i ^ xneg_i;
          base_q <= xneg_i;
        end
      end
      C_NORM: begin
        if (is_zero) begin
          res_q <= '0;
        end else if (is_big) begin
          mx_q <= {1'b0, mx_q[63:1]};
          my_q <= {1'b0, my_q[63:1]};
        end else if (is_small) begin
          mx_q <= {mx_q[62:0], 1'b0};
          my_q <= {my_q[62:0], 1'b0};
        end else begin
          x_q   <= $signed(mx_q);
          y_q   <= yn_q ? -$signed(my_q) : $signed(my_q);
          ang_q <= '0;
          idx_q <= '0;
        end
      end
      C_ITER: begin
        x_q   <= x_nx;
        y_q   <= y_nx;
        ang_q <= ang_nx;
        idx_q <= idx_q + 1'b1;
        res_q <= {base_q, 63'd0} + ang_nx;
      end
      default: ;
    endcase
  end

  assign done_o  = done_q;
  assign angle_o = res_q;

endmodule

// ----- rtl/core/c2g_datapath.sv -----
// c2g_datapath: configuration registers, working registers and the shared
// multiply, root/divide and cordic units. Depends on c2g_pkg, c2g_mul,
// c2g_rootdiv and c2g_cordic.
module c2g_datapath import c2g_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  input  cmd_t                          cmd_i,
  output status_t                       status_o,
  output logic signed [ANGLE_WIDTH-1:0] longitude_o,
  output logic signed [ANGLE_WIDTH-1:0] latitude_o,
  output logic signed [COORD_WIDTH-1:0] altitude_o,
  output logic                          invalid_input_o,
  output logic                          not_converged_o
);

  localparam logic [63:0] HMAX       = (64'd1 << (COORD_WIDTH - 1)) - 64'd1;
  localparam logic [63:0] ROUND_HALF = 64'd1 << (63 - ANGLE_WIDTH);
  localparam logic [63:0] NEG_MAX    = 64'h8000_0000_0000_0001;

  logic [39:0]  radius_q;
  logic [31:0]  ecc_q;
  logic [15:0]  thresh_q;
  logic [6:0]   maxit_q, lim, iter_q;

  logic [63:0]  ax_q, ay_q, az_q, dz_q, zdz_q, nh_q, root_q, n_q, u_q, dmag_q, rho_q;
  logic [63:0]  lon_q, lat_q;
  logic [127:0] rho2_q, wsum_q;
  logic [31:0]  sm_q, s2_q;
  logic [32:0]  dval_q;
  logic         xneg_q, yneg_q, zneg_q, zero_q, conv_q, stuck_q, loc_done_q;
  op_e          op_q;

  logic [ANGLE_WIDTH-1:0] lon_out_q, lat_out_q;
  logic [COORD_WIDTH-1:0] alt_out_q;
  logic                   inv_out_q, nc_out_q;

  logic [63:0]  mx, my, mz, z_s, azd, dzn, diff, zdz_nx;
  logic [64:0]  sum65;
  logic         conv_nx, is_local;

  logic         mul_start, mul_done;
  logic [63:0]  mul_a, mul_b;
  logic [127:0] prod;

  logic         rd_start, rd_done;
  rd_mode_e     rd_mode;
  logic [127:0] rd_num;
  logic [63:0]  rd_den, rd_res;

  logic         cor_start, cor_done, cor_yneg, cor_xneg;
  logic [63:0]  cor_ay, cor_ax, cor_ang;

  function automatic logic [63:0] coord_mag(input logic [COORD_WIDTH-1:0] v);
    logic [63:0] sx;
    logic [63:0] m;
    sx = 64'($signed(v));
    m  = v[COORD_WIDTH-1] ? (~sx + 64'd1) : sx;
    return m[63] ? INT64_MAX : m;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] height_out(input logic neg,
                                                        input logic [63:0] mag);
    logic [63:0] m;
    m = mag;
    if (!neg) begin
      if (m > HMAX) m = HMAX;
    end else begin
      if (m > HMAX + 64'd1) m = HMAX + 64'd1;
      m = ~m + 64'd1;
    end
    return m[COORD_WIDTH-1:0];
  endfunction

  function automatic logic [ANGLE_WIDTH-1:0] angle_out(input logic [63:0] a);
    logic [63:0] r;
    r = a + ROUND_HALF;
    return r[63 -: ANGLE_WIDTH];
  endfunction

  // coordinate reads, saturated z + dz, the convergence test and the iteration limit
  always_comb begin
    mx      = coord_mag(pos_x_i);
    my      = coord_mag(pos_y_i);
    mz      = coord_mag(pos_z_i);
    z_s     = zneg_q ? (~az_q + 64'd1) : az_q;
    sum65   = {z_s[63], z_s} + {dz_q[63], dz_q};
    if ($signed(sum65) > $signed({1'b0, INT64_MAX})) begin
      zdz_nx = INT64_MAX;
    end else if ($signed(sum65) < $signed({1'b1, NEG_MAX})) begin
      zdz_nx = NEG_MAX;
    end else begin
      zdz_nx = sum65[63:0];
    end
    azd     = zdz_q[63] ? (~zdz_q + 64'd1) : zdz_q;
    dzn     = zdz_q[63] ? (~dmag_q + 64'd1) : dmag_q;
    diff    = ($signed(dz_q) >= $signed(dzn)) ? (dz_q - dzn) : (dzn - dz_q);
    conv_nx = diff < {48'd0, thresh_q};
    if (maxit_q == 7'd0) begin
      lim = 7'd1;
    end else if (maxit_q > MAXIT_CAP) begin
      lim = MAXIT_CAP;
    end else begin
      lim = maxit_q;
    end
  end

  // unit launch and operand selection
  always_comb begin
    mul_start = 1'b0;
    rd_start  = 1'b0;
    cor_start = 1'b0;
    is_local  = 1'b0;
    mul_a     = ax_q;
    mul_b     = ax_q;
    rd_mode   = RD_SQRT;
    rd_num    = rho2_q;
    rd_den    = nh_q;
    cor_yneg  = yneg_q;
    cor_ay    = ay_q;
    cor_xneg  = xneg_q;
    cor_ax    = ax_q;
    case (cmd_i.op)
      OP_RHOX: begin
        mul_start = cmd_i.go;
      end
      OP_RHOY: begin
        mul_start = cmd_i.go;
        mul_a     = ay_q;
        mul_b     = ay_q;
      end
      OP_DZ0: begin
        mul_start = cmd_i.go;
        mul_a     = az_q;
        mul_b     = {32'd0, ecc_q};
      end
      OP_NH2: begin
        mul_start = cmd_i.go;
        mul_a     = azd;
        mul_b     = azd;
      end
      OP_S2: begin
        mul_start = cmd_i.go;
        mul_a     = {32'd0, sm_q};
        mul_b     = {32'd0, sm_q};
      end
      OP_ES2: begin
        mul_start = cmd_i.go;
        mul_a     = {32'd0, ecc_q};
        mul_b     = {32'd0, s2_q};
      end
      OP_NE: begin
        mul_start = cmd_i.go;
        mul_a     = n_q;
        mul_b     = {32'd0, ecc_q};
      end
      OP_DMAG: begin
        mul_start = cmd_i.go;
        mul_a     = u_q;
        mul_b     = {32'd0, sm_q};
      end
      OP_NH: begin
        rd_start = cmd_i.go;
        rd_num   = wsum_q;
      end
      OP_SIN: begin
        rd_start = cmd_i.go;
        rd_mode  = RD_DIV;
        rd_num   = {32'd0, azd, 32'd0};
        rd_den   = nh_q;
      end
      OP_ROOT: begin
        rd_start = cmd_i.go;
        rd_num   = {63'd0, dval_q, 32'd0};
      end
      OP_N: begin
        rd_start = cmd_i.go;
        rd_mode  = RD_DIV;
        rd_num   = {56'd0, radius_q, 32'd0};
        rd_den   = root_q;
      end
      OP_RHO: begin
        rd_start = cmd_i.go;
      end
      OP_LON: begin
        cor_start = cmd_i.go;
      end
      OP_LAT: begin
        cor_start = cmd_i.go;
        cor_yneg  = zdz_q[63];
        cor_ay    = azd;
        cor_xneg  = 1'b0;
        cor_ax    = rho_q;
      end
      default: begin
        is_local = 1'b1;
      end
    endcase
  end

  c2g_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  c2g_rootdiv u_rootdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rd_start),
    .mode_i  (rd_mode),
    .num_i   (rd_num),
    .den_i   (rd_den),
    .done_o  (rd_done),
    .res_o   (rd_res)
  );

  c2g_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .yneg_i  (cor_yneg),
    .ay_i    (cor_ay),
    .xneg_i  (cor_xneg),
    .ax_i    (cor_ax),
    .done_o  (cor_done),
    .angle_o (cor_ang)
  );

  // configuration and control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= RADIUS_RST;
      ecc_q      <= ECC_RST;
      thresh_q   <= THRESH_RST;
      maxit_q    <= MAXIT_RST;
      loc_done_q <= 1'b0;
      op_q       <= OP_LOAD;
      zero_q     <= 1'b0;
      conv_q     <= 1'b0;
      stuck_q    <= 1'b0;
      iter_q     <= 7'd1;
    end else begin
      loc_done_q <= cmd_i.go && is_local;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RADIUS: radius_q <= cfg_data_i[39:0];
          CFG_ECC:    ecc_q    <= cfg_data_i[31:0];
          CFG_THRESH: thresh_q <= cfg_data_i[15:0];
          CFG_MAXIT:  maxit_q  <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (cmd_i.go) begin
        op_q <= cmd_i.op;
        if (cmd_i.op == OP_LOAD) begin
          zero_q  <= (mx == 64'd0) && (my == 64'd0) && (mz == 64'd0);
          conv_q  <= 1'b0;
          stuck_q <= 1'b0;
          iter_q  <= 7'd1;
        end else if (cmd_i.op == OP_CHECK) begin
          conv_q  <= conv_nx;
          stuck_q <= !conv_nx && (iter_q >= lim);
          if (!conv_nx && (iter_q < lim)) begin
            iter_q <= iter_q + 7'd1;
          end
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.go) begin
      case (cmd_i.op)
        OP_LOAD: begin
          ax_q   <= mx;
          ay_q   <= my;
          az_q   <= mz;
          xneg_q <= pos_x_i[COORD_WIDTH-1];
          yneg_q <= pos_y_i[COORD_WIDTH-1];
          zneg_q <= pos_z_i[COORD_WIDTH-1];
        end
        OP_ZDZ: begin
          zdz_q <= zdz_nx;
        end
        OP_CHECK: begin
          if (!conv_nx && (iter_q < lim)) begin
            dz_q <= dzn;
          end
        end
        OP_OUT: begin
          if (zero_q) begin
            lon_out_q <= '0;
            lat_out_q <= '0;
            alt_out_q <= height_out(1'b1, {24'd0, radius_q});
            inv_out_q <= 1'b1;
            nc_out_q  <= 1'b0;
          end else begin
            lon_out_q <= angle_out(lon_q);
            lat_out_q <= angle_out(lat_q);
            alt_out_q <= (nh_q >= n_q) ? height_out(1'b0, nh_q - n_q)
                                       : height_out(1'b1, n_q - nh_q);
            inv_out_q <= 1'b0;
            nc_out_q  <= stuck_q;
          end
        end
        default: ;
      endcase
    end
    if (mul_done) begin
      case (op_q)
        OP_RHOX: rho2_q <= prod;
        OP_RHOY: rho2_q <= rho2_q + prod;
        OP_DZ0:  dz_q   <= zneg_q ? (~prod[95:32] + 64'd1) : prod[95:32];
        OP_NH2:  wsum_q <= rho2_q + prod;
        OP_S2:   s2_q   <= prod[63:32];
        OP_ES2:  dval_q <= 33'h1_0000_0000 - {1'b0, prod[63:32]};
        OP_NE:   u_q    <= prod[95:32];
        OP_DMAG: dmag_q <= prod[95:32];
        default: ;
      endcase
    end
    if (rd_done) begin
      case (op_q)
        OP_NH:   nh_q   <= rd_res;
        OP_SIN:  sm_q   <= (nh_q == 64'd0) ? 32'd0
                         : ((rd_res[63:32] != 32'd0) ? LOW32[31:0] : rd_res[31:0]);
        OP_ROOT: root_q <= rd_res;
        OP_N:    n_q    <= rd_res;
        OP_RHO:  rho_q  <= rd_res;
        default: ;
      endcase
    end
    if (cor_done) begin
      if (op_q == OP_LON) begin
        lon_q <= cor_ang;
      end else begin
        lat_q <= cor_ang;
      end
    end
  end

  assign status_o.done   = loc_done_q | mul_done | rd_done | cor_done;
  assign status_o.zero   = zero_q;
  assign status_o.conv   = conv_q;
  assign status_o.stuck  = stuck_q;
  assign longitude_o     = lon_out_q;
  assign latitude_o      = lat_out_q;
  assign altitude_o      = alt_out_q;
  assign invalid_input_o = inv_out_q;
  assign not_converged_o = nc_out_q;

endmodule

// ----- rtl/core/c2g_ctrl.sv -----
// c2g_ctrl: sequencer that steps the datapath through load, the height
// correction loop, the angle evaluation and the result strobe. Depends on c2g_pkg.
module c2g_ctrl import c2g_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  output logic    done_o,
  output cmd_t    cmd_o,
  input  status_t status_i
);

  typedef enum logic [20:0] {
    S_IDLE  = 21'h000001,
    S_LOAD  = 21'h000002,
    S_RHOX  = 21'h000004,
    S_RHOY  = 21'h000008,
    S_DZ0   = 21'h000010,
    S_ZDZ   = 21'h000020,
    S_NH2   = 21'h000040,
    S_NH    = 21'h000080,
    S_SIN   = 21'h000100,
    S_S2    = 21'h000200,
    S_ES2   = 21'h000400,
    S_ROOT  = 21'h000800,
    S_N     = 21'h001000,
    S_NE    = 21'h002000,
    S_DMAG  = 21'h004000,
    S_CHECK = 21'h008000,
    S_RHO   = 21'h010000,
    S_LON   = 21'h020000,
    S_LAT   = 21'h040000,
    S_OUT   = 21'h080000,
    S_DONE  = 21'h100000
  } state_e;

  state_e state_q, state_d;
  logic   launched_q;
  op_e    op;

  always_comb begin
    case (state_q)
      S_RHOX:  op = OP_RHOX;
      S_RHOY:  op = OP_RHOY;
      S_DZ0:   op = OP_DZ0;
      S_ZDZ:   op = OP_ZDZ;
      S_NH2:   op = OP_NH2;
      S_NH:    op = OP_NH;
      S_SIN:   op = OP_SIN;
      S_S2:    op = OP_S2;
      S_ES2:   op = OP_ES2;
      S_ROOT:  op = OP_ROOT;
      S_N:     op = OP_N;
      S_NE:    op = OP_NE;
      S_DMAG:  op = OP_DMAG;
      S_CHECK: op = OP_CHECK;
      S_RHO:   op = OP_RHO;
      S_LON:   op = OP_LON;
      S_LAT:   op = OP_LAT;
      S_OUT:   op = OP_OUT;
      default: op = OP_LOAD;
    endcase
  end

  always_comb begin
    cmd_o.op = op;
    case (state_q)
      S_IDLE:  cmd_o.go = start;
      S_DONE:  cmd_o.go = 1'b0;
      default: cmd_o.go = !launched_q;
    endcase
  end

  always_comb begin
    case (state_q)
      S_IDLE:  state_d = S_LOAD;
      S_LOAD:  state_d = status_i.zero ? S_OUT : S_RHOX;
      S_RHOX:  state_d = S_RHOY;
      S_RHOY:  state_d = S_DZ0;
      S_DZ0:   state_d = S_ZDZ;
      S_ZDZ:   state_d = S_NH2;
      S_NH2:   state_d = S_NH;
      S_NH:    state_d = S_SIN;
      S_SIN:   state_d = S_S2;
      S_S2:    state_d = S_ES2;
      S_ES2:   state_d = S_ROOT;
      S_ROOT:  state_d = S_N;
      S_N:     state_d = S_NE;
      S_NE:    state_d = S_DMAG;
      S_DMAG:  state_d = S_CHECK;
      S_CHECK: state_d = (status_i.conv || status_i.stuck) ? S_RHO : S_ZDZ;
      S_RHO:   state_d = S_LON;
      S_LON:   state_d = S_LAT;
      S_LAT:   state_d = S_OUT;
      S_OUT:   state_d = S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      launched_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q    <= state_d;
            launched_q <= 1'b1;
          end
        end
        S_DONE: begin
          state_q    <= S_IDLE;
          launched_q <= 1'b0;
        end
        default: begin
          if (status_i.done) begin
            state_q    <= state_d;
            launched_q <= 1'b0;
          end else if (cmd_o.go) begin
            launched_q <= 1'b1;
          end
        end
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_go_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.go |=> !cmd_o.go) else $error("step launched twice");

  a_done_launched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.done |-> launched_q) else $error("unit done without a launched step");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted transfer did not raise busy");

endmodule

// ----- rtl/core/cartesian_to_geodetic.sv -----
// cartesian_to_geodetic: top level, earth-fixed position to longitude,
// latitude and height. Depends on c2g_pkg, c2g_ctrl and c2g_datapath.
//
// channel  | handshake            | payload
// ---------+----------------------+--------------------------------------------
// input    | start, busy          | pos_x_i, pos_y_i, pos_z_i
// result   | done_o (strobe)      | longitude_o, latitude_o, altitude_o,
//          |                      | invalid_input_o, not_converged_o
// config   | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// one position at a time; each height iteration takes four passes through the
// shared 64-step root/divide unit, and each angle takes the 62-step cordic
// after its normalizing shifts. an all-zero vector goes from load straight
// to the result strobe.
// reset restores the ellipsoid defaults; the result strobe cannot be stalled.
module cartesian_to_geodetic import c2g_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  output logic                          done_o,
  output logic signed [ANGLE_WIDTH-1:0] longitude_o,
  output logic signed [ANGLE_WIDTH-1:0] latitude_o,
  output logic signed [COORD_WIDTH-1:0] altitude_o,
  output logic                          invalid_input_o,
  output logic                          not_converged_o
);

  cmd_t    cmd;
  status_t status;

  c2g_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  c2g_datapath #(
    .COORD_WIDTH (COORD_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .longitude_o     (longitude_o),
    .latitude_o      (latitude_o),
    .altitude_o      (altitude_o),
    .invalid_input_o (invalid_input_o),
    .not_converged_o (not_converged_o)
  );

endmodule
